[src/mko_pkg.sv]
// shared types and fixed-point constants for the mecanum kinematics and odometry block
// no dependencies
package mko_pkg;

    typedef logic signed [15:0] t_q16;     // Q3.12 velocity and wheel speed
    typedef logic signed [31:0] t_pose;    // Q15.16 position
    typedef logic signed [34:0] t_opa;     // multiplier a operand, cordic x/y
    typedef logic signed [30:0] t_opb;     // multiplier b operand
    typedef logic signed [65:0] t_prod;    // full product
    typedef logic signed [25:0] t_ang;     // cordic residual angle, 2^-24 turn

    localparam logic [15:0] GEOM_RESET   = 16'd8192;
    localparam t_opb        SQRT2_Q16    = 31'sd92682;
    localparam t_opb        GAIN_Q24     = 31'sd10188014;
    localparam t_opb        RAD2BAM_Q16  = 31'sd683565276;
    localparam int          CORDIC_STEPS = 18;

    localparam logic ACT_CMD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // arctan(2^-i) in 2^-24 turn
    function automatic t_ang atan_lut(input logic [4:0] idx);
        t_ang v;
        case (idx)
            5'd0:    v = 26'sd2097152;
            5'd1:    v = 26'sd1238021;
            5'd2:    v = 26'sd654136;
            5'd3:    v = 26'sd332050;
            5'd4:    v = 26'sd166669;
            5'd5:    v = 26'sd83416;
            5'd6:    v = 26'sd41718;
            5'd7:    v = 26'sd20860;
            5'd8:    v = 26'sd10430;
            5'd9:    v = 26'sd5215;
            5'd10:   v = 26'sd2608;
            5'd11:   v = 26'sd1304;
            5'd12:   v = 26'sd652;
            5'd13:   v = 26'sd326;
            5'd14:   v = 26'sd163;
            5'd15:   v = 26'sd81;
            5'd16:   v = 26'sd41;
            5'd17:   v = 26'sd20;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

[src/mecanum_kinematics_odometry.sv]
// A velocity command runs CROT, CSAVE, then WMUL and WSAT for each wheel; a tick with
// nonzero delta_time runs TMX, TMY, TPRE, THD, THD2, the cordic rotation in CORD, GX,
// GY and GY2; a tick with zero delta_time goes straight to DONE. One transaction at a time:
// the next input is taken the cycle after the result loads; a stalled held result delays
// the load by the stall. One shared 35x31 multiplier and one shared cordic add/shift stage.
// Reset (synchronous, active low): geometry_sum 8192, commands, pose and heading zero.
module mecanum_kinematics_odometry (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [15:0]         i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_action,
    input  mko_pkg::t_q16       i_vel_x,
    input  mko_pkg::t_q16       i_vel_y,
    input  mko_pkg::t_q16       i_yaw_rate,
    input  logic [15:0]         i_delta_time,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_kind,
    output mko_pkg::t_q16       o_left_front,
    output mko_pkg::t_q16       o_left_back,
    output mko_pkg::t_q16       o_right_front,
    output mko_pkg::t_q16       o_right_back,
    output mko_pkg::t_pose      o_pose_x,
    output mko_pkg::t_pose      o_pose_y,
    output logic [15:0]         o_heading
);
    import mko_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CROT  = 4'd1;
    localparam logic [3:0] S_CSAVE = 4'd2;
    localparam logic [3:0] S_WMUL  = 4'd3;
    localparam logic [3:0] S_WSAT  = 4'd4;
    localparam logic [3:0] S_TMX   = 4'd5;
    localparam logic [3:0] S_TMY   = 4'd6;
    localparam logic [3:0] S_TPRE  = 4'd7;
    localparam logic [3:0] S_THD   = 4'd8;
    localparam logic [3:0] S_THD2  = 4'd9;
    localparam logic [3:0] S_CORD  = 4'd10;
    localparam logic [3:0] S_GX    = 4'd11;
    localparam logic [3:0] S_GY    = 4'd12;
    localparam logic [3:0] S_GY2   = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0]  r_state, n_state;
    logic [4:0]  r_cnt;
    logic [15:0] r_geom;
    t_q16        r_cmd_vx, r_cmd_vy, r_cmd_wz;
    t_pose       r_pos_x, r_pos_y;
    logic [15:0] r_angle;
    logic [15:0] r_dt;
    logic [15:0] r_dth;
    logic        r_kind;
    t_opa        r_x, r_y;
    t_ang        r_z;
    t_prod       r_prod;
    t_q16        r_wheel [4];

    logic        r_out_valid;
    logic        r_out_kind;
    t_q16        r_out_lf, r_out_lb, r_out_rf, r_out_rb;
    t_pose       r_out_px, r_out_py;
    logic [15:0] r_out_hd;

    logic        in_acc, out_acc, out_load;
    t_opa        mul_a;
    t_opb        mul_b;
    t_prod       product;
    t_prod       rnd_k, rnd_sum;
    logic [1:0]  widx;
    logic signed [16:0] lin17;
    logic signed [33:0] wsum;
    logic signed [33:0] wrnd;
    t_q16        wsat;
    t_opa        y_ld;
    t_opa        pre_x, pre_y;
    logic signed [15:0] ang_s, pre_t;
    t_opa        xs, ys;
    t_ang        atan_v;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_out_valid && !i_stall;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // wheel sums: lf (vx-vy)-rot, lb (vx+vy)-rot, rf (vx+vy)+rot, rb (vx-vy)+rot
    assign widx  = r_cnt[1:0];
    always_comb begin
        if (widx[0] ^ widx[1]) begin
            lin17 = 17'(r_cmd_vx) + 17'(r_cmd_vy);
        end else begin
            lin17 = 17'(r_cmd_vx) - 17'(r_cmd_vy);
        end
        if (widx[1]) begin
            wsum = {lin17[16], lin17, 16'b0} + 34'(r_x);
        end else begin
            wsum = {lin17[16], lin17, 16'b0} - 34'(r_x);
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_CROT: begin
                mul_a = 35'(r_cmd_wz);
                mul_b = 31'({15'b0, r_geom});
            end
            S_WMUL: begin
                mul_a = 35'(wsum);
                mul_b = SQRT2_Q16;
            end
            S_TMX: begin
                mul_a = 35'(r_cmd_vx);
                mul_b = 31'({15'b0, r_dt});
            end
            S_TMY: begin
                mul_a = 35'(r_cmd_vy);
                mul_b = 31'({15'b0, r_dt});
            end
            S_TPRE: begin
                mul_a = 35'(r_cmd_wz);
                mul_b = 31'({15'b0, r_dt});
            end
            S_THD: begin
                mul_a = 35'(signed'(r_prod[31:0]));
                mul_b = RAD2BAM_Q16;
            end
            S_GX: begin
                mul_a = r_x;
                mul_b = GAIN_Q24;
            end
            S_GY: begin
                mul_a = r_y;
                mul_b = GAIN_Q24;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // round-to-nearest offset for the following right shift
    always_comb begin
        case (r_state)
            S_WSAT:  rnd_k = 66'sh8000_0000;
            S_GY:    rnd_k = 66'sh8_0000_0000;
            S_GY2:   rnd_k = 66'sh8_0000_0000;
            S_THD2:  rnd_k = 66'sh800_0000_0000;
            default: rnd_k = '0;
        endcase
    end

    assign rnd_sum = r_prod + rnd_k;
    assign wrnd    = rnd_sum[65:32];

    always_comb begin
        if (wrnd > 34'sd32767) begin
            wsat = 16'sh7fff;
        end else if (wrnd < -34'sd32768) begin
            wsat = 16'sh8000;
        end else begin
            wsat = wrnd[15:0];
        end
    end

    // quarter-turn pre-rotation so the cordic only sees +-90 degrees
    assign ang_s = signed'(r_angle);
    assign y_ld  = 35'(signed'(r_prod[31:0]));
    always_comb begin
        if (ang_s > 16'sd16384) begin
            pre_x = -y_ld;
            pre_y = r_x;
            pre_t = ang_s - 16'sd16384;
        end else if (ang_s < -16'sd16384) begin
            pre_x = y_ld;
            pre_y = -r_x;
            pre_t = ang_s + 16'sd16384;
        end else begin
            pre_x = r_x;
            pre_y = y_ld;
            pre_t = ang_s;
        end
    end

    assign xs     = r_x >>> r_cnt;
    assign ys     = r_y >>> r_cnt;
    assign atan_v = atan_lut(r_cnt);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_action == ACT_CMD) begin
                        n_state = S_CROT;
                    end else if (i_delta_time == 16'd0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_TMX;
                    end
                end
            end
            S_CROT:  n_state = S_CSAVE;
            S_CSAVE: n_state = S_WMUL;
            S_WMUL:  n_state = S_WSAT;
            S_WSAT:  n_state = (widx == 2'd3) ? S_DONE : S_WMUL;
            S_TMX:   n_state = S_TMY;
            S_TMY:   n_state = S_TPRE;
            S_TPRE:  n_state = S_THD;
            S_THD:   n_state = S_THD2;
            S_THD2:  n_state = S_CORD;
            S_CORD:  n_state = (r_cnt == 5'(CORDIC_STEPS - 1)) ? S_GX : S_CORD;
            S_GX:    n_state = S_GY;
            S_GY:    n_state = S_GY2;
            S_GY2:   n_state = S_DONE;
            S_DONE:  n_state = out_load ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= product;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_geom      <= GEOM_RESET;
            r_cmd_vx    <= '0;
            r_cmd_vy    <= '0;
            r_cmd_wz    <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_angle     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_geom <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind <= i_action;
                        r_dt   <= i_delta_time;
                        r_cnt  <= '0;
                        if (i_action == ACT_CMD) begin
                            r_cmd_vx <= i_vel_x;
                            r_cmd_vy <= i_vel_y;
                            r_cmd_wz <= i_yaw_rate;
                        end
                    end
                end
                S_CSAVE: begin
                    r_x <= 35'(signed'(r_prod[31:0]));
                end
                S_WSAT: begin
                    r_wheel[widx] <= wsat;
                    r_cnt         <= r_cnt + 5'd1;
                end
                S_TMY: begin
                    r_x <= 35'(signed'(r_prod[31:0]));
                end
                S_TPRE: begin
                    r_x <= pre_x;
                    r_y <= pre_y;
                    r_z <= {{2{pre_t[15]}}, pre_t, 8'b0};
                end
                S_THD2: begin
                    r_dth <= rnd_sum[59:44];
                    r_cnt <= '0;
                end
                S_CORD: begin
                    if (!r_z[25]) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atan_v;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atan_v;
                    end
                    r_cnt <= r_cnt + 5'd1;
                end
                S_GY: begin
                    r_pos_x <= r_pos_x + 32'(signed'(rnd_sum[65:36]));
                end
                S_GY2: begin
                    r_pos_y <= r_pos_y + 32'(signed'(rnd_sum[65:36]));
                    r_angle <= r_angle + r_dth;
                end
                default: begin
                end
            endcase
        end
    end

    // output register, other kind's fields read as zero
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind <= r_kind;
            if (r_kind == ACT_TICK) begin
                r_out_lf <= '0;
                r_out_lb <= '0;
                r_out_rf <= '0;
                r_out_rb <= '0;
                r_out_px <= r_pos_x;
                r_out_py <= r_pos_y;
                r_out_hd <= r_angle;
            end else begin
                r_out_lf <= r_wheel[0];
                r_out_lb <= r_wheel[1];
                r_out_rf <= r_wheel[2];
                r_out_rb <= r_wheel[3];
                r_out_px <= '0;
                r_out_py <= '0;
                r_out_hd <= '0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_left_front  = r_out_lf;
    assign o_left_back   = r_out_lb;
    assign o_right_front = r_out_rf;
    assign o_right_back  = r_out_rb;
    assign o_pose_x      = r_out_px;
    assign o_pose_y      = r_out_py;
    assign o_heading     = r_out_hd;

endmodule
